### hw/rtl/msgq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the message FIFO queue.
// No dependencies; imported by msgq_cmdq, msgq_front, msgq_back and the top level.
package msgq_pkg;

    localparam int WORD_BYTES        = 4;
    localparam int LANE_W            = $clog2(WORD_BYTES);
    localparam int BYTE_W            = 8;
    localparam int DATA_W            = WORD_BYTES * BYTE_W;
    localparam int CNT_W             = 3;
    localparam int CAP_W             = 16;
    localparam int MSG_LEN_W         = 9;
    localparam int SLOT_FIELD_W      = 8;
    localparam int CMDQ_DEPTH        = 4;
    localparam int MAX_MESSAGES_DEF  = 16;
    localparam int MESSAGE_BYTES_DEF = 256;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_SMALL = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // One command handed from the front to the back.
    typedef struct packed {
        logic                    is_stream;
        t_status                 status;
        logic [MSG_LEN_W-1:0]    len;
        logic [SLOT_FIELD_W-1:0] slot;
    } t_cmd;

    // Back-to-front feedback.
    typedef struct packed {
        logic stream_done;
    } t_back_stat;

endpackage

### hw/rtl/message_fifo_queue_unit.sv
`timescale 1ns / 1ps
// Message FIFO queue: a ring of fixed message slots fed and drained by beats.
// Depends on msgq_pkg, msgq_ram, msgq_cmdq, msgq_front, msgq_back.
//
// Input channel (i_in_valid / o_in_stall): a write beat carries up to four
// bytes, first byte lowest; the beat with i_last closes the message and gives
// one result beat (ok with stored length, or queue full). Bytes past the slot
// size are dropped. A read beat gives one status beat (empty, or reader buffer
// too small, message kept) or removes the front message and streams it as
// words, end_of_run on the last one; an empty message gives one ok beat.
// Output channel (o_out_valid / i_out_stall): each result is one beat.
// Throughput: a write beat is taken every cycle unless the front stalls; a read
// beat holds the front in its read state for the slot-length RAM lookup. Stream
// words leave at one per cycle while the receiver does not stall, set by the
// single read port of the byte-lane RAMs. A write result passes the command
// queue, the back's read stage and the output register; a read first waits in
// the front's read state, and a stream also waits for the back's pop.
// The front stalls during a read's lookup, while the command queue is full, and
// while the slot the next write would fill is still being streamed out.
// A stalled receiver holds the output register; the back then stops reading
// and the queue fills, so the front stalls in turn. No beat is lost.
// Reset (synchronous, active low) empties the ring; message RAMs are not
// cleared, as only written slots are ever read.
module message_fifo_queue_unit #(
    parameter int MAX_MESSAGES  = msgq_pkg::MAX_MESSAGES_DEF,
    parameter int MESSAGE_BYTES = msgq_pkg::MESSAGE_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_req_type,
    input  logic [msgq_pkg::DATA_W-1:0]    i_data_word,
    input  logic [msgq_pkg::CNT_W-1:0]     i_byte_count,
    input  logic                           i_last,
    input  logic [msgq_pkg::CAP_W-1:0]     i_read_capacity,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_status,
    output logic [msgq_pkg::DATA_W-1:0]    o_out_word,
    output logic [msgq_pkg::CNT_W-1:0]     o_out_bytes,
    output logic [msgq_pkg::MSG_LEN_W-1:0] o_msg_length,
    output logic                           o_end_of_run
);
    import msgq_pkg::*;

    localparam int ROWS   = (MESSAGE_BYTES + WORD_BYTES - 1) / WORD_BYTES;
    localparam int DEPTH  = MAX_MESSAGES * ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // byte-lane write side (front) and shared read side (back)
    logic [WORD_BYTES-1:0]              lane_we;
    logic [WORD_BYTES-1:0][ADDR_W-1:0]  lane_addr;
    logic [WORD_BYTES-1:0][BYTE_W-1:0]  lane_wdata;
    logic [WORD_BYTES-1:0][BYTE_W-1:0]  lane_rdata;
    logic                               rd_en;
    logic [ADDR_W-1:0]                  rd_addr;

    // command queue between front and back
    logic       q_push, q_full, q_pop, q_empty;
    t_cmd       q_cmd_in, q_cmd_out;
    t_back_stat back_stat;

    msgq_front #(
        .MAX_MESSAGES  (MAX_MESSAGES),
        .MESSAGE_BYTES (MESSAGE_BYTES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_stall         (o_in_stall),
        .i_req_type      (i_req_type),
        .i_data_word     (i_data_word),
        .i_byte_count    (i_byte_count),
        .i_last          (i_last),
        .i_read_capacity (i_read_capacity),
        .o_lane_we       (lane_we),
        .o_lane_addr     (lane_addr),
        .o_lane_data     (lane_wdata),
        .o_push          (q_push),
        .o_cmd           (q_cmd_in),
        .i_q_full        (q_full),
        .i_back          (back_stat)
    );

    msgq_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd_out),
        .o_empty (q_empty)
    );

    // one RAM per byte lane, each with its own address, so an unaligned write beat can straddle two rows
    for (genvar g = 0; g < WORD_BYTES; g++) begin : g_lane
        msgq_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_lane_ram (
            .i_clk   (i_clk),
            .i_we    (lane_we[g]),
            .i_waddr (lane_addr[g]),
            .i_wdata (lane_wdata[g]),
            .i_re    (rd_en),
            .i_raddr (rd_addr),
            .o_rdata (lane_rdata[g])
        );
    end

    msgq_back #(
        .MAX_MESSAGES  (MAX_MESSAGES),
        .MESSAGE_BYTES (MESSAGE_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_cmd        (q_cmd_out),
        .o_pop        (q_pop),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (lane_rdata),
        .o_stat       (back_stat),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_status     (o_status),
        .o_out_word   (o_out_word),
        .o_out_bytes  (o_out_bytes),
        .o_msg_length (o_msg_length),
        .o_end_of_run (o_end_of_run)
    );

endmodule

### hw/rtl/msgq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msgq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/msgq_cmdq.sv
`timescale 1ns / 1ps
// Small register FIFO of commands between the front and the back.
// Depends on msgq_pkg.
module msgq_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  msgq_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output msgq_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import msgq_pkg::*;

    localparam int QW = $clog2(CMDQ_DEPTH);

    t_cmd          r_mem [CMDQ_DEPTH];
    logic [QW-1:0] r_wp, r_rp;
    logic [QW:0]   r_cnt;

    assign o_full  = (r_cnt == (QW + 1)'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QW + 1)'(i_push) - (QW + 1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("command queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("command queue pop while empty");

endmodule

### hw/rtl/msgq_front.sv
`timescale 1ns / 1ps
// Front end: accepts beats, writes message bytes, tracks ring pointers and
// classifies each closing write and read into a command. Depends on msgq_pkg, msgq_ram.
module msgq_front #(
    parameter int MAX_MESSAGES  = msgq_pkg::MAX_MESSAGES_DEF,
    parameter int MESSAGE_BYTES = msgq_pkg::MESSAGE_BYTES_DEF,
    localparam int ROWS   = (MESSAGE_BYTES + msgq_pkg::WORD_BYTES - 1) / msgq_pkg::WORD_BYTES,
    localparam int DEPTH  = MAX_MESSAGES * ROWS,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_req_type,
    input  logic [msgq_pkg::DATA_W-1:0]       i_data_word,
    input  logic [msgq_pkg::CNT_W-1:0]        i_byte_count,
    input  logic                              i_last,
    input  logic [msgq_pkg::CAP_W-1:0]        i_read_capacity,
    output logic [msgq_pkg::WORD_BYTES-1:0]   o_lane_we,
    output logic [msgq_pkg::WORD_BYTES-1:0][ADDR_W-1:0] o_lane_addr,
    output logic [msgq_pkg::WORD_BYTES-1:0][msgq_pkg::BYTE_W-1:0] o_lane_data,
    output logic                              o_push,
    output msgq_pkg::t_cmd                    o_cmd,
    input  logic                              i_q_full,
    input  msgq_pkg::t_back_stat              i_back
);
    import msgq_pkg::*;

    localparam int SLOT_W = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;
    localparam int OCC_W  = $clog2(MAX_MESSAGES + 1);
    localparam int FILL_W = $clog2(MESSAGE_BYTES + 1);

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_RD   = 2'b10
    } t_fstate;

    t_fstate           r_fst, n_fst;
    logic [SLOT_W-1:0] r_head, n_head, r_tail, n_tail;
    logic [OCC_W-1:0]  r_occ, n_occ, r_pend, n_pend;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_drop, n_drop;
    logic [CAP_W-1:0]  r_cap;

    logic              full_now, hazard, acc, wr, rd_acc, drop_now, close_ok;
    logic              pop_msg, start_strm;
    logic [CNT_W-1:0]  cnt_sat;
    logic [FILL_W-1:0] room, take, fill_next;
    logic [LANE_W-1:0] off;
    logic [ADDR_W-1:0] row_base;
    logic [FILL_W-1:0] len_rd;
    logic              len_fits;

    msgq_ram #(.WIDTH(FILL_W), .DEPTH(MAX_MESSAGES)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (close_ok),
        .i_waddr (r_tail),
        .i_wdata (fill_next),
        .i_re    (rd_acc),
        .i_raddr (r_head),
        .o_rdata (len_rd)
    );

    always_comb begin
        logic [LANE_W-1:0] k;

        full_now = (r_occ == OCC_W'(MAX_MESSAGES));
        // a write must not land in a slot the back is still streaming out
        hazard   = !full_now &&
                   (({1'b0, r_occ} + {1'b0, r_pend}) >= (OCC_W + 1)'(MAX_MESSAGES));
        o_stall  = (r_fst != F_IDLE) || i_q_full || hazard;
        acc      = i_valid && !o_stall;
        wr       = acc && !i_req_type;
        rd_acc   = acc && i_req_type;

        cnt_sat   = (i_byte_count > CNT_W'(WORD_BYTES)) ? CNT_W'(WORD_BYTES) : i_byte_count;
        drop_now  = r_drop || full_now;
        room      = FILL_W'(MESSAGE_BYTES) - r_fill;
        take      = (FILL_W'(cnt_sat) < room) ? FILL_W'(cnt_sat) : room;
        fill_next = r_fill + take;
        close_ok  = wr && i_last && !drop_now;

        off      = r_fill[LANE_W-1:0];
        row_base = ADDR_W'(r_tail) * ADDR_W'(ROWS) + ADDR_W'(r_fill >> LANE_W);
        for (int l = 0; l < WORD_BYTES; l++) begin
            k              = LANE_W'(l) - off;
            o_lane_we[l]   = wr && !drop_now && (FILL_W'(k) < take);
            o_lane_addr[l] = row_base + ADDR_W'(LANE_W'(l) < off);
            o_lane_data[l] = i_data_word[{k, 3'b000} +: BYTE_W];
        end

        len_fits   = (CAP_W'(len_rd) <= r_cap);
        pop_msg    = (r_fst == F_RD) && !i_q_full && (r_occ != '0) && len_fits;
        start_strm = pop_msg && (len_rd != '0);

        o_push = 1'b0;
        o_cmd  = '0;
        if (wr && i_last) begin
            o_push     = 1'b1;
            o_cmd.status = drop_now ? ST_FULL : ST_OK;
            o_cmd.len    = MSG_LEN_W'(fill_next);
        end else if ((r_fst == F_RD) && !i_q_full) begin
            o_push = 1'b1;
            priority if (r_occ == '0) begin
                o_cmd.status = ST_EMPTY;
            end else if (!len_fits) begin
                o_cmd.status = ST_SMALL;
                o_cmd.len    = MSG_LEN_W'(len_rd);
            end else begin
                // zero-length messages come back as a plain status beat
                o_cmd.status    = ST_OK;
                o_cmd.len       = MSG_LEN_W'(len_rd);
                o_cmd.is_stream = (len_rd != '0);
                o_cmd.slot      = SLOT_FIELD_W'(r_head);
            end
        end

        n_fst = r_fst;
        unique case (r_fst)
            F_IDLE: if (rd_acc) n_fst = F_RD;
            F_RD:   if (!i_q_full) n_fst = F_IDLE;
            default: n_fst = F_IDLE;
        endcase

        n_fill = r_fill;
        n_drop = r_drop;
        if (wr) begin
            n_fill = i_last ? '0 : fill_next;
            n_drop = i_last ? 1'b0 : drop_now;
        end

        n_tail = r_tail;
        if (close_ok) begin
            n_tail = (r_tail == SLOT_W'(MAX_MESSAGES - 1)) ? '0 : r_tail + 1'b1;
        end
        n_head = r_head;
        if (pop_msg) begin
            n_head = (r_head == SLOT_W'(MAX_MESSAGES - 1)) ? '0 : r_head + 1'b1;
        end
        n_occ  = r_occ + OCC_W'(close_ok) - OCC_W'(pop_msg);
        n_pend = r_pend + OCC_W'(start_strm) - OCC_W'(i_back.stream_done);
    end

    always_ff @(posedge i_clk) begin
        if (rd_acc) begin
            r_cap <= i_read_capacity;
        end
        if (!i_rst_n) begin
            r_fst  <= F_IDLE;
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
            r_pend <= '0;
            r_fill <= '0;
            r_drop <= 1'b0;
        end else begin
            r_fst  <= n_fst;
            r_head <= n_head;
            r_tail <= n_tail;
            r_occ  <= n_occ;
            r_pend <= n_pend;
            r_fill <= n_fill;
            r_drop <= n_drop;
        end
    end

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(MAX_MESSAGES))
        else $error("occupancy beyond slot count");

    a_slots_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_occ} + {1'b0, r_pend}) <= (OCC_W + 1)'(MAX_MESSAGES))
        else $error("queued plus streaming slots exceed ring size");

    a_done_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_back.stream_done |-> (r_pend != '0))
        else $error("stream finished with none outstanding");

endmodule

### hw/rtl/msgq_back.sv
`timescale 1ns / 1ps
// Back end: pops commands, streams message words from the byte-lane RAMs and
// drives the output register. Depends on msgq_pkg.
module msgq_back #(
    parameter int MAX_MESSAGES  = msgq_pkg::MAX_MESSAGES_DEF,
    parameter int MESSAGE_BYTES = msgq_pkg::MESSAGE_BYTES_DEF,
    localparam int ROWS   = (MESSAGE_BYTES + msgq_pkg::WORD_BYTES - 1) / msgq_pkg::WORD_BYTES,
    localparam int DEPTH  = MAX_MESSAGES * ROWS,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  msgq_pkg::t_cmd                i_cmd,
    output logic                          o_pop,
    output logic                          o_rd_en,
    output logic [ADDR_W-1:0]             o_rd_addr,
    input  logic [msgq_pkg::WORD_BYTES-1:0][msgq_pkg::BYTE_W-1:0] i_rd_data,
    output msgq_pkg::t_back_stat          o_stat,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_status,
    output logic [msgq_pkg::DATA_W-1:0]   o_out_word,
    output logic [msgq_pkg::CNT_W-1:0]    o_out_bytes,
    output logic [msgq_pkg::MSG_LEN_W-1:0] o_msg_length,
    output logic                          o_end_of_run
);
    import msgq_pkg::*;

    localparam int SLOT_W = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_STRM = 2'b10
    } t_bstate;

    typedef struct packed {
        t_status              status;
        logic [MSG_LEN_W-1:0] len;
        logic [CNT_W-1:0]     nbytes;
        logic                 eor;
        logic                 use_data;
    } t_beat;

    t_bstate              r_bst, n_bst;
    logic [ADDR_W-1:0]    r_base, n_base;
    logic [ROW_W-1:0]     r_row, n_row;
    logic [MSG_LEN_W-1:0] r_rem, n_rem, r_len, n_len;
    logic                 r_s1_v, n_s1_v;
    t_beat                r_s1, n_s1;
    logic                 r_o_v;
    logic                 out_free, adv, last_word;
    logic [DATA_W-1:0]    masked;

    assign out_free  = !r_o_v || !i_stall;
    assign adv       = !r_s1_v || out_free;
    assign last_word = (r_rem <= MSG_LEN_W'(WORD_BYTES));
    assign o_rd_addr = r_base + ADDR_W'(r_row);

    always_comb begin
        o_pop              = 1'b0;
        o_rd_en            = 1'b0;
        o_stat.stream_done = 1'b0;
        n_bst  = r_bst;
        n_base = r_base;
        n_row  = r_row;
        n_rem  = r_rem;
        n_len  = r_len;
        n_s1_v = adv ? 1'b0 : r_s1_v;
        n_s1   = r_s1;
        if (adv) begin
            unique case (r_bst)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        o_pop = 1'b1;
                        if (i_cmd.is_stream) begin
                            n_base = ADDR_W'(SLOT_W'(i_cmd.slot)) * ADDR_W'(ROWS);
                            n_row  = '0;
                            n_rem  = i_cmd.len;
                            n_len  = i_cmd.len;
                            n_bst  = B_STRM;
                        end else begin
                            n_s1_v = 1'b1;
                            n_s1   = '{status: i_cmd.status, len: i_cmd.len,
                                       nbytes: '0, eor: 1'b1, use_data: 1'b0};
                        end
                    end
                end
                B_STRM: begin
                    o_rd_en = 1'b1;
                    n_s1_v  = 1'b1;
                    n_s1    = '{status: ST_OK, len: r_len,
                                nbytes: last_word ? CNT_W'(r_rem) : CNT_W'(WORD_BYTES),
                                eor: last_word, use_data: 1'b1};
                    n_rem   = r_rem - MSG_LEN_W'(WORD_BYTES);
                    n_row   = r_row + 1'b1;
                    if (last_word) begin
                        n_bst              = B_IDLE;
                        o_stat.stream_done = 1'b1;
                    end
                end
                default: n_bst = B_IDLE;
            endcase
        end

        // bytes past the end of the message are stale RAM contents
        for (int b = 0; b < WORD_BYTES; b++) begin
            masked[b*BYTE_W +: BYTE_W] = (CNT_W'(b) < r_s1.nbytes) ? i_rd_data[b] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_row  <= n_row;
        r_rem  <= n_rem;
        r_len  <= n_len;
        r_s1   <= n_s1;
        if (out_free) begin
            o_status     <= r_s1.status;
            o_out_word   <= r_s1.use_data ? masked : '0;
            o_out_bytes  <= r_s1.nbytes;
            o_msg_length <= r_s1.len;
            o_end_of_run <= r_s1.eor;
        end
        if (!i_rst_n) begin
            r_bst  <= B_IDLE;
            r_s1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            r_bst  <= n_bst;
            r_s1_v <= n_s1_v;
            if (out_free) begin
                r_o_v <= r_s1_v;
            end
        end
    end

    assign o_valid = r_o_v;

endmodule
